@@ sv/b64_pkg.sv @@
package b64_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            last;
		status_t         status;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// bit 6 set: character is in the alphabet (pad counts as zero)
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			t = 8'd62;
		end else if (c == 8'h2F) begin
			t = 8'd63;
		end else if (c == PAD_CHAR) begin
			t = 8'd0;
		end else begin
			return 7'h00;
		end
		return {1'b1, t[5:0]};
	endfunction

endpackage

@@ sv/b64_ifs.sv @@
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [1:0] status;

	modport source(output valid, output out_byte, output out_last, output status,
		input ready);
	modport sink(input valid, input out_byte, input out_last, input status,
		output ready);
endinterface

@@ sv/base64_codec.sv @@
// Base64 codec, one byte per input request.
// The item completing a group is written into the job queue; its first result
// is then loaded into the output register once that register is free.
// Throughput: one input request per cycle while the two-entry job queue has
// room; the output stage emits one result per cycle while the sink is ready;
// encode gives four characters per three bytes, decode up to three per four.
// Reset: arst_n clears mode to encode, the group state and the queue.
module base64_codec #(
	parameter int QueueDepth = b64_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	b64_in_if.sink    in_chan,
	b64_out_if.source out_chan
);
	import b64_pkg::*;

	logic job_valid;
	job_t job;
	logic not_full;
	logic pop;
	logic head_valid;
	job_t head;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_chan   (in_chan),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (not_full)
	);

	b64_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.wdata      (job),
		.not_full   (not_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_chan   (out_chan)
	);

endmodule

@@ sv/b64_front.sv @@
module b64_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	b64_in_if.sink        in_chan,
	output logic          job_valid,
	output b64_pkg::job_t job,
	input  logic          job_ready
);
	import b64_pkg::*;

	mode_t       mode_q;
	logic [23:0] group_q, group_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [1:0]  pad_q, pad_d;
	logic        discard_q, discard_d;

	logic        accept;
	logic [23:0] ebits;
	logic [6:0]  sx;
	logic [23:0] dbits;
	logic [1:0]  pad_new;

	assign in_chan.ready = job_ready;
	assign accept = in_chan.valid & job_ready;

	always_comb begin
		group_d   = group_q;
		cnt_d     = cnt_q;
		pad_d     = pad_q;
		discard_d = discard_q;
		job_valid = 1'b0;
		job       = '0;
		ebits     = {group_q[15:0], in_chan.in_byte};
		sx        = char_sextet(in_chan.in_byte);
		dbits     = {group_q[17:0], sx[5:0]};
		pad_new   = 2'd0;
		if (in_chan.in_byte == PAD_CHAR) begin
			pad_new = (pad_q == 2'd3) ? 2'd3 : pad_q + 2'd1;
		end
		case (cnt_q)
			2'd0:    ebits = {in_chan.in_byte, 16'h0000};
			2'd1:    ebits = {group_q[7:0], in_chan.in_byte, 8'h00};
			default: ebits = {group_q[15:0], in_chan.in_byte};
		endcase

		if (accept) begin
			if (mode_q == MODE_ENCODE) begin
				if (cnt_q != 2'd2 && !in_chan.in_last) begin
					group_d = {group_q[15:0], in_chan.in_byte};
					cnt_d   = cnt_q + 2'd1;
				end else begin
					job_valid    = 1'b1;
					job.data[0]  = sextet_char(ebits[23:18]);
					job.data[1]  = sextet_char(ebits[17:12]);
					job.data[2]  = (cnt_q != 2'd0) ? sextet_char(ebits[11:6]) : PAD_CHAR;
					job.data[3]  = (cnt_q == 2'd2) ? sextet_char(ebits[5:0]) : PAD_CHAR;
					job.last_idx = 2'd3;
					job.last     = in_chan.in_last;
					job.status   = ST_OK;
					group_d      = '0;
					cnt_d        = 2'd0;
					pad_d        = 2'd0;
				end
			end else if (discard_q) begin
				if (in_chan.in_last) begin
					discard_d = 1'b0;
				end
			end else if (!sx[6]) begin
				job_valid  = 1'b1;
				job.last   = 1'b1;
				job.status = ST_BAD_CHAR;
				group_d    = '0;
				cnt_d      = 2'd0;
				pad_d      = 2'd0;
				discard_d  = !in_chan.in_last;
			end else if (cnt_q != 2'd3) begin
				if (in_chan.in_last) begin
					job_valid  = 1'b1;
					job.last   = 1'b1;
					job.status = ST_BAD_LEN;
					group_d    = '0;
					cnt_d      = 2'd0;
					pad_d      = 2'd0;
				end else begin
					group_d = dbits;
					cnt_d   = cnt_q + 2'd1;
					pad_d   = pad_new;
				end
			end else begin
				job_valid    = 1'b1;
				job.data[0]  = dbits[23:16];
				job.data[1]  = dbits[15:8];
				job.data[2]  = dbits[7:0];
				job.last_idx = 2'd2;
				if (in_chan.in_last) begin
					if (pad_new >= 2'd2) begin
						job.last_idx = 2'd0;
					end else if (pad_new == 2'd1) begin
						job.last_idx = 2'd1;
					end
				end
				job.last   = in_chan.in_last;
				job.status = ST_OK;
				group_d    = '0;
				cnt_d      = 2'd0;
				pad_d      = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ENCODE;
			group_q   <= '0;
			cnt_q     <= 2'd0;
			pad_q     <= 2'd0;
			discard_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q    <= mode_t'(cfg_data);
			group_q   <= '0;
			cnt_q     <= 2'd0;
			pad_q     <= 2'd0;
			discard_q <= 1'b0;
		end else begin
			group_q   <= group_d;
			cnt_q     <= cnt_d;
			pad_q     <= pad_d;
			discard_q <= discard_d;
		end
	end

endmodule

@@ sv/b64_queue.sv @@
module b64_queue #(
	parameter int Depth = b64_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  b64_pkg::job_t wdata,
	output logic          not_full,
	input  logic          pop,
	output logic          head_valid,
	output b64_pkg::job_t head
);
	import b64_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign not_full   = (count_q != CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ sv/b64_back.sv @@
module b64_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  b64_pkg::job_t head,
	output logic          pop,
	b64_out_if.source     out_chan
);
	import b64_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	status_t    status_q;
	logic       adv;
	logic       load;
	logic       final_res;

	assign adv       = !out_valid_q || out_chan.ready;
	assign load      = adv && head_valid;
	assign final_res = (idx_q == head.last_idx);
	assign pop       = load && final_res;

	assign out_chan.valid    = out_valid_q;
	assign out_chan.out_byte = out_byte_q;
	assign out_chan.out_last = out_last_q;
	assign out_chan.status   = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (adv) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.data[idx_q];
			out_last_q <= head.last && final_res;
			status_q   <= head.status;
		end
	end

endmodule

@@ tb/base64_codec_tb.sv @@
`timescale 1ns / 100ps

module base64_codec_tb;
	import b64_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} b64_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		status_t    st;
	} b64_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	b64_in_if  req_if ();
	b64_out_if rsp_if ();

	base64_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_chan  (req_if),
		.out_chan (rsp_if)
	);

	b64_req_t    pending_reqs[$];
	b64_result_t expected_results[$];

	// codec state as predicted
	mode_t       cur_mode;
	logic [23:0] grp_bits;
	int          grp_cnt;
	int          pad_cnt;
	bit          discard;

	bit req_taken;
	int req_count;
	int enc_reqs;
	int dec_reqs;
	int result_count;
	int error_results;
	int mismatches;
	int queued_count;
	int stall_left;
	bit hold_done;

	wire calm = (req_count >= 110) && (req_count < 150);

	function automatic logic [7:0] to_b64_char(logic [5:0] v);
		string alpha;
		alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		return alpha[v];
	endfunction

	function automatic int b64_value(logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return int'(c) - 65;
		end
		if (c >= "a" && c <= "z") begin
			return int'(c) - 97 + 26;
		end
		if (c >= "0" && c <= "9") begin
			return int'(c) - 48 + 52;
		end
		if (c == "+") begin
			return 62;
		end
		if (c == "/") begin
			return 63;
		end
		if (c == PAD_CHAR) begin
			return 0;
		end
		return -1;
	endfunction

	function automatic void add_expected(logic [7:0] ch, logic fin, status_t st);
		b64_result_t r;
		r.ch = ch;
		r.fin = fin;
		r.st = st;
		expected_results.push_back(r);
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_cnt = 0;
		pad_cnt = 0;
	endfunction

	task automatic predict_codec(logic [7:0] b, logic fin);
		int n;
		int v;
		int keep;
		logic [23:0] bits;
		logic [23:0] sh_bits;
		if (cur_mode == MODE_ENCODE) begin
			n = grp_cnt + 1;
			bits = {grp_bits[15:0], b};
			if (n < 3 && !fin) begin
				grp_bits = bits;
				grp_cnt = n;
				return;
			end
			if (n == 1) begin
				bits = bits << 16;
			end else if (n == 2) begin
				bits = bits << 8;
			end
			add_expected(to_b64_char(bits[23:18]), 1'b0, ST_OK);
			add_expected(to_b64_char(bits[17:12]), 1'b0, ST_OK);
			add_expected(n >= 2 ? to_b64_char(bits[11:6]) : PAD_CHAR, 1'b0, ST_OK);
			add_expected(n >= 3 ? to_b64_char(bits[5:0]) : PAD_CHAR, fin, ST_OK);
			clear_group();
			return;
		end
		if (discard) begin
			if (fin) begin
				discard = 0;
			end
			return;
		end
		v = b64_value(b);
		if (v < 0) begin
			clear_group();
			if (!fin) begin
				discard = 1;
			end
			add_expected(8'h00, 1'b1, ST_BAD_CHAR);
			return;
		end
		if (b == PAD_CHAR) begin
			if (pad_cnt < 3) begin
				pad_cnt++;
			end
		end else begin
			pad_cnt = 0;
		end
		n = grp_cnt + 1;
		bits = {grp_bits[17:0], v[5:0]};
		if (n < 4) begin
			if (fin) begin
				clear_group();
				add_expected(8'h00, 1'b1, ST_BAD_LEN);
				return;
			end
			grp_bits = bits;
			grp_cnt = n;
			return;
		end
		keep = 3;
		if (fin) begin
			keep -= (pad_cnt > 2) ? 2 : pad_cnt;
		end
		for (int k = 0; k < keep; k++) begin
			sh_bits = bits >> (16 - 8 * k);
			add_expected(sh_bits[7:0], fin && (k + 1 == keep), ST_OK);
		end
		clear_group();
	endtask

	function automatic void push_req(logic [7:0] data, logic fin);
		b64_req_t r;
		r.data = data;
		r.fin = fin;
		pending_reqs.push_back(r);
		queued_count++;
	endfunction

	function automatic void send_text(string s, bit fin);
		for (int i = 0; i < s.len(); i++) begin
			push_req(s[i], fin && (i == s.len() - 1));
		end
	endfunction

	function automatic void send_bytes(logic [7:0] msg[$]);
		for (int i = 0; i < msg.size(); i++) begin
			push_req(msg[i], i == msg.size() - 1);
		end
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (b64_value(c) >= 0) begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic void add_encode_msg();
		logic [7:0] msg[$];
		int len;
		len = $urandom_range(1, 9);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				msg.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
			end else begin
				msg.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_bytes(msg);
	endfunction

	function automatic void add_decode_msg();
		logic [7:0] msg[$];
		int r;
		int q;
		int p;
		int len;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			q = $urandom_range(1, 3);
			for (int i = 0; i < 4 * q; i++) begin
				msg.push_back(to_b64_char(6'($urandom_range(0, 63))));
			end
			if (q > 1 && $urandom_range(0, 4) == 0) begin
				msg[$urandom_range(0, 4 * q - 5)] = PAD_CHAR;
			end
			p = $urandom_range(0, 4);
			for (int i = 0; i < p; i++) begin
				msg[4 * q - 1 - i] = PAD_CHAR;
			end
		end else if (r < 80) begin
			len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
			for (int i = 0; i < len; i++) begin
				msg.push_back($urandom_range(0, 7) == 0 ? PAD_CHAR :
					to_b64_char(6'($urandom_range(0, 63))));
			end
		end else if (r < 92) begin
			len = 4 * $urandom_range(1, 3);
			for (int i = 0; i < len; i++) begin
				msg.push_back(to_b64_char(6'($urandom_range(0, 63))));
			end
			msg[$urandom_range(0, len - 1)] = bad_char();
		end else begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				msg.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_bytes(msg);
	endfunction

	task automatic wait_drained(int settle);
		while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_mode(mode_t m);
		wait_drained(8);
		cfg_data <= m;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		req_if.valid = 1'b0;
		req_if.in_byte = '0;
		req_if.in_last = 1'b0;
		rsp_if.ready = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("base64_codec_tb NOT OK");
		$finish;
	end

	// sender: hold the request until taken, then advance
	always @(negedge clk) begin : sender
		b64_req_t nxt;
		if (arst_n) begin
			if (!req_if.valid || req_taken) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
					nxt = pending_reqs.pop_front();
					req_if.in_byte <= nxt.data;
					req_if.in_last <= nxt.fin;
					req_if.valid <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (!hold_done && req_count >= 50) begin
				hold_done = 1;
				stall_left = 90;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= calm || ($urandom_range(0, 99) >= 13);
			end
		end
	end

	always @(posedge clk) begin : monitor
		b64_result_t exp_r;
		req_taken = 0;
		if (arst_n) begin
			if (cfg_we) begin
				cur_mode = mode_t'(cfg_data);
				clear_group();
				discard = 0;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				result_count++;
				if (rsp_if.status != ST_OK) begin
					error_results++;
				end
				if (expected_results.size() == 0) begin
					if (mismatches < 10) begin
						$display("unexpected result: byte %02h last %0d status %0d",
							rsp_if.out_byte, rsp_if.out_last, rsp_if.status);
					end
					mismatches++;
				end else begin
					exp_r = expected_results.pop_front();
					if (rsp_if.out_byte !== exp_r.ch || rsp_if.out_last !== exp_r.fin ||
						rsp_if.status !== exp_r.st) begin
						if (mismatches < 10) begin
							$display({"mismatch: expected byte %02h last %0d status %0d,",
								" got byte %02h last %0d status %0d"},
								exp_r.ch, exp_r.fin, exp_r.st,
								rsp_if.out_byte, rsp_if.out_last, rsp_if.status);
						end
						mismatches++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				req_taken = 1;
				req_count++;
				if (cur_mode == MODE_ENCODE) begin
					enc_reqs++;
				end else begin
					dec_reqs++;
				end
				predict_codec(req_if.in_byte, req_if.in_last);
			end
		end
	end

	initial begin : stimulus
		int mark;
		cur_mode = MODE_ENCODE;
		clear_group();
		discard = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// encode: full group, one-byte and two-byte tails
		push_req(8'h00, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req(8'h80, 1'b1);
		push_req(8'hFF, 1'b1);
		push_req(8'h00, 1'b0);
		push_req(8'h01, 1'b1);
		// partial group dropped by a mode write
		push_req(8'hFB, 1'b0);
		write_mode(MODE_ENCODE);
		push_req(8'h3E, 1'b1);

		write_mode(MODE_DECODE);
		send_text("QQ==", 1'b1);
		send_text("/+9z", 1'b1);
		send_text("=Az9", 1'b0);
		push_req("*", 1'b0);
		send_text("xy", 1'b1);
		send_text("Ab", 1'b1);
		push_req("~", 1'b1);

		write_mode(MODE_ENCODE);
		mark = queued_count;
		while (queued_count < mark + 64) begin
			add_encode_msg();
		end

		write_mode(MODE_DECODE);
		mark = queued_count;
		while (queued_count < mark + 32) begin
			add_decode_msg();
		end
		wait_drained(0);
		while (queued_count < mark + 64) begin
			add_decode_msg();
		end

		wait_drained(10);
		$display("covered %0d requests (%0d encode, %0d decode)",
			req_count, enc_reqs, dec_reqs);
		$display("checked %0d results (%0d errors) through hold-off and drain, %0d mismatches",
			result_count, error_results, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("base64_codec_tb OK");
		end else begin
			$display("base64_codec_tb NOT OK");
		end
		$finish;
	end

endmodule
